// ===== sv/assert_macros.svh =====
// Assertion helper macros used by wpf_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication assertion with async active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Concurrent next-cycle implication assertion.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/wpf_pkg.sv =====
//------------------------------------------------------------------------------
// wpf_pkg
// Shared types and constants of the waypoint path follower.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package wpf_pkg;
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_PATH = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] REG_REACH = 2'd0;
  localparam logic [1:0] REG_TURN  = 2'd1;
  localparam logic [1:0] REG_FAST  = 2'd2;

  localparam int unsigned ATAN_LEN = 24;

  typedef logic [31:0] angle_t;

  // atan(2^-i) as a 32-bit binary angle.
  function automatic angle_t atan_turn(input logic [4:0] i);
    angle_t r;
    r = '0;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10680350;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_SQ,
    ST_SUM,
    ST_CMP,
    ST_ADD,
    ST_CORDIC,
    ST_STEER,
    ST_OUT
  } state_e;
endpackage

// ===== sv/wpf_cordic.sv =====
//------------------------------------------------------------------------------
// wpf_cordic
// Iterative vectoring CORDIC, one step per cycle, giving a 16-bit bearing.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module wpf_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [33:0]  dx_i,
  input  logic [33:0]  dy_i,
  output logic         done_o,
  output logic [15:0]  bearing_o
);
  import wpf_pkg::*;

  // Operands are differences of two 32-bit values; the registers add three bits for growth.
  logic signed [36:0] x_q, x_d, y_q, y_d;
  angle_t             z_q, z_d;
  logic [4:0]         i_q, i_d;
  logic               busy_q, busy_d, zero_q, zero_d;
  logic signed [36:0] xs, ys;
  logic [31:0]        zr;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    busy_d = busy_q;
    zero_d = zero_q;
    done_o = 1'b0;
    if (start_i) begin
      zero_d = (dx_i == '0) && (dy_i == '0);
      busy_d = 1'b1;
      i_d = '0;
      if (dx_i[33]) begin
        x_d = -{{3{dx_i[33]}}, dx_i};
        y_d = -{{3{dy_i[33]}}, dy_i};
        z_d = 32'h8000_0000;
      end else begin
        x_d = {{3{dx_i[33]}}, dx_i};
        y_d = {{3{dy_i[33]}}, dy_i};
        z_d = '0;
      end
    end else if (busy_q) begin
      if (32'(i_q) == STEPS || 32'(i_q) == ATAN_LEN) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (!y_q[36]) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_turn(i_q);
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_turn(i_q);
        end
        i_d = i_q + 5'd1;
      end
    end
  end

  assign zr = z_q + 32'h0000_8000;
  assign bearing_o = zero_q ? 16'd0 : zr[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    i_q <= i_d;
    zero_q <= zero_d;
  end
endmodule

// ===== sv/waypoint_path_follower.sv =====
// A command takes one transaction. Loads and path commands are answered from the idle state
// without a memory scan. A control tick reads the waypoint memory one entry per step; each
// distance test runs through memory read, difference, absolute value, squaring, sum and
// compare steps. A tick that acquires the nearest point first scans the whole path, then
// runs the skip tests, the CORDIC and steering; later ticks run one distance test per
// skipped waypoint, then the CORDIC and steering unless the last waypoint is reached.
// The FSM runs one distance test at a time. No clearing pass is needed after reset.
//------------------------------------------------------------------------------
// waypoint_path_follower
// Waypoint memory, nearest-point search, skip and steering sequencer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module waypoint_path_follower #(
  parameter int unsigned PATH_DEPTH   = 1024,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic [9:0]           point_index_i,
  input  logic signed [31:0]   point_x_i,
  input  logic signed [31:0]   point_y_i,
  input  logic [10:0]          path_count_i,
  input  logic signed [31:0]   robot_x_i,
  input  logic signed [31:0]   robot_y_i,
  input  logic [15:0]          robot_heading_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 drive_valid_o,
  output logic                 drive_forward_o,
  output logic signed [1:0]    turn_dir_o,
  output logic                 reached_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [30:0]          cfg_data_i
);
  import wpf_pkg::*;

  localparam int unsigned AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PATH_DEPTH + 1);

  logic [63:0] mem_q [PATH_DEPTH];
  logic [63:0] rd_q;

  logic [30:0] reach_q;
  logic [14:0] turn_tol_q, fast_tol_q;
  logic [CW-1:0] len_q, len_d, tgt_q, tgt_d, idx_q, idx_d, best_i_q, best_i_d;
  logic pend_q, pend_d, acq_q, acq_d;
  state_e st_q, st_d;

  logic signed [31:0] rx_q, ry_q;
  logic [15:0] head_q;
  logic [32:0] ax_q, ay_q, ax_d, ay_d;
  logic [65:0] sx_q, sy_q;
  logic [66:0] d2_q;
  logic [63:0] d2s, best_q, best_d;
  logic [61:0] r2_q;
  logic [33:0] dx_q, dy_q, dx_d, dy_d;
  logic first_q, first_d;

  logic out_v_q, out_v_d, dv_q, dv_d, fw_q, fw_d, rc_q, rc_d;
  logic signed [1:0] tn_q, tn_d;

  logic cstart, cdone;
  logic [15:0] bear;
  logic signed [16:0] err;
  logic signed [15:0] e16;
  logic [15:0] ae;
  logic [10:0] pc_sat;
  logic [63:0] mem_wdata;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic close;

  wpf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cstart),
    .dx_i(dx_q), .dy_i(dy_q), .done_o(cdone), .bearing_o(bear)
  );

  assign in_ready_o = (st_q == ST_IDLE) && !out_v_q;
  assign mem_we = in_valid_i && in_ready_o && (cmd_i == CMD_LOAD)
                  && (32'(point_index_i) < PATH_DEPTH);
  assign mem_waddr = AW'(point_index_i);
  assign mem_wdata = {point_x_i, point_y_i};
  assign mem_raddr = idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  assign pc_sat = (32'(path_count_i) > PATH_DEPTH) ? 11'(PATH_DEPTH) : path_count_i;
  assign d2s = d2_q[66:64] != '0 ? 64'hFFFF_FFFF_FFFF_FFFF : d2_q[63:0];
  assign close = ({d2s, 2'b00} <= {4'b0, r2_q}) && (d2s[63:62] == 2'b00);

  always_comb begin
    e16 = close ? -$signed(head_q) : $signed(bear - head_q);
    err = {e16[15], e16};
    ae = e16[15] ? 16'(-err) : 16'(err);
  end

  always_comb begin
    st_d = st_q;
    len_d = len_q;
    tgt_d = tgt_q;
    idx_d = idx_q;
    pend_d = pend_q;
    acq_d = acq_q;
    best_d = best_q;
    best_i_d = best_i_q;
    first_d = first_q;
    ax_d = ax_q;
    ay_d = ay_q;
    dx_d = dx_q;
    dy_d = dy_q;
    out_v_d = out_v_q;
    dv_d = dv_q;
    fw_d = fw_q;
    tn_d = tn_q;
    rc_d = rc_q;
    cstart = 1'b0;
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          dv_d = 1'b0; fw_d = 1'b0; tn_d = 2'sd0; rc_d = 1'b0;
          if (cmd_i == CMD_PATH) begin
            len_d = CW'(pc_sat);
            tgt_d = '0;
            pend_d = 1'b1;
            out_v_d = 1'b1;
          end else if (cmd_i == CMD_TICK) begin
            pend_d = 1'b0;
            if (tgt_q < len_q) begin
              acq_d = pend_q;
              first_d = 1'b1;
              idx_d = pend_q ? '0 : tgt_q;
              st_d = ST_RD;
            end else begin
              out_v_d = 1'b1;
            end
          end else begin
            out_v_d = 1'b1;
          end
        end
      end
      ST_RD: st_d = ST_SQ;
      ST_SQ: begin
        dx_d = 34'($signed(rd_q[63:32])) - 34'(rx_q);
        dy_d = 34'($signed(rd_q[31:0])) - 34'(ry_q);
        st_d = ST_SUM;
      end
      ST_SUM: begin
        ax_d = dx_q[33] ? 33'(-dx_q) : dx_q[32:0];
        ay_d = dy_q[33] ? 33'(-dy_q) : dy_q[32:0];
        st_d = ST_CMP;
      end
      ST_CMP: begin
        // Squares and their sum are registered in the datapath block below.
        st_d = ST_ADD;
      end
      ST_ADD: begin
        st_d = ST_CORDIC;
        if (acq_q) begin
          st_d = ST_STEER;
        end
      end
      ST_STEER: begin
        if (acq_q) begin
          // Nearest-point scan step; first entry wins ties.
          if (first_q || d2s < best_q) begin
            best_d = d2s;
            best_i_d = idx_q;
          end
          first_d = 1'b0;
          if (idx_q + 1'b1 < len_q) begin
            idx_d = idx_q + 1'b1;
            st_d = ST_RD;
          end else begin
            acq_d = 1'b0;
            tgt_d = (first_q || d2s < best_q) ? idx_q : best_i_q;
            idx_d = (first_q || d2s < best_q) ? idx_q : best_i_q;
            st_d = ST_RD;
          end
        end else begin
          st_d = ST_OUT;
        end
      end
      ST_CORDIC: begin
        // Skip test on the current target.
        if ({2'b0, d2s} <= {4'b0, r2_q}) begin
          if (tgt_q + 1'b1 >= len_q) begin
            tgt_d = len_q;
            rc_d = 1'b1;
            out_v_d = 1'b1;
            st_d = ST_IDLE;
          end else begin
            tgt_d = tgt_q + 1'b1;
            idx_d = tgt_q + 1'b1;
            st_d = ST_RD;
          end
        end else begin
          cstart = 1'b1;
          st_d = ST_STEER;
        end
      end
      ST_OUT: begin
        if (cdone) begin
          dv_d = 1'b1;
          if (close) begin
            fw_d = 1'b0;
          end else begin
            fw_d = ae <= {1'b0, fast_tol_q};
          end
          if ($signed(err) > $signed({2'b0, turn_tol_q})) begin
            tn_d = 2'sd1;
          end else if ($signed(err) < -$signed({2'b0, turn_tol_q})) begin
            tn_d = -2'sd1;
          end else begin
            tn_d = 2'sd0;
          end
          rc_d = close && (err <= $signed({2'b0, turn_tol_q}))
                 && (err >= -$signed({2'b0, turn_tol_q}));
          out_v_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      len_q <= '0;
      tgt_q <= '0;
      pend_q <= 1'b1;
      acq_q <= 1'b0;
      out_v_q <= 1'b0;
      reach_q <= 31'd19661;
      turn_tol_q <= 15'd1365;
      fast_tol_q <= 15'd5461;
    end else begin
      st_q <= st_d;
      len_q <= len_d;
      tgt_q <= tgt_d;
      pend_q <= pend_d;
      acq_q <= acq_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_REACH: reach_q <= cfg_data_i;
          REG_TURN:  turn_tol_q <= cfg_data_i[14:0];
          REG_FAST:  fast_tol_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rx_q <= robot_x_i;
      ry_q <= robot_y_i;
      head_q <= robot_heading_i;
    end
    r2_q <= 62'(reach_q) * 62'(reach_q);
    idx_q <= idx_d;
    best_q <= best_d;
    best_i_q <= best_i_d;
    first_q <= first_d;
    ax_q <= ax_d;
    ay_q <= ay_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
    if (st_q == ST_CMP) begin
      sx_q <= 66'(ax_q) * 66'(ax_q);
      sy_q <= 66'(ay_q) * 66'(ay_q);
    end
    d2_q <= 67'(sx_q) + 67'(sy_q);
    dv_q <= dv_d;
    fw_q <= fw_d;
    tn_q <= tn_d;
    rc_q <= rc_d;
  end

  assign out_valid_o = out_v_q;
  assign drive_valid_o = dv_q;
  assign drive_forward_o = fw_q;
  assign turn_dir_o = tn_q;
  assign reached_o = rc_q;
endmodule

// ===== sv/wpf_checker.sv =====
//------------------------------------------------------------------------------
// wpf_checker
// Port-level checks of the waypoint path follower.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wpf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              drive_valid_o,
  input logic              drive_forward_o,
  input logic signed [1:0] turn_dir_o,
  input logic              reached_o
);
  `ASSERT_IMPL(a_turn_code, clk_i, rst_ni, out_valid_o, turn_dir_o != 2'b10)
  `ASSERT_IMPL(a_fwd_needs_valid, clk_i, rst_ni, out_valid_o && drive_forward_o, drive_valid_o)
  `ASSERT_IMPL(a_no_accept_pending, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

bind waypoint_path_follower wpf_checker u_wpf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .drive_valid_o(drive_valid_o),
  .drive_forward_o(drive_forward_o), .turn_dir_o(turn_dir_o), .reached_o(reached_o)
);
